// ===== hdl/sitda_pkg.sv =====
package sitda_pkg;

	// Input width and the number of decimal digits its magnitude can need
	localparam int WIDTH = 32;
	localparam int NDIG  = (WIDTH * 30103) / 100000 + 1;
	localparam int CNT_W = $clog2(WIDTH);
	localparam int REM_W = $clog2(NDIG + 1);

	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_MINUS = 8'd45;

	typedef logic [3:0] digit_t;

	// Per-cycle command to every digit cell
	typedef struct packed {
		logic clear;  // zero the digit
		logic dab;    // add-3 correct, then shift in one binary bit
		logic mov;    // take the digit of the lower neighbor
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_EMIT
	} state_t;

endpackage

// ===== hdl/sitda_cell.sv =====
module sitda_cell (
	input  logic                 clk,
	input  sitda_pkg::cell_ctl_t ctl,
	input  logic                 bit_in,
	input  sitda_pkg::digit_t    digit_in,
	output logic                 carry_out,
	output sitda_pkg::digit_t    digit
);
	import sitda_pkg::*;

	digit_t digit_q;
	digit_t adj;

	// Correct a digit of five or more so the next doubling carries out
	always_comb begin
		adj       = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
		carry_out = adj[3];
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			digit_q <= '0;
		end else if (ctl.dab) begin
			digit_q <= {adj[2:0], bit_in};
		end else if (ctl.mov) begin
			digit_q <= digit_in;
		end
	end

	assign digit = digit_q;

endmodule

// ===== hdl/sitda_chain.sv =====
module sitda_chain (
	input  logic                 clk,
	input  sitda_pkg::cell_ctl_t ctl,
	input  logic                 bit_in,
	output sitda_pkg::digit_t    top_digit,
	output logic                 top_carry
);
	import sitda_pkg::*;

	logic   [NDIG:0] carry;
	digit_t          digits [NDIG];

	assign carry[0] = bit_in;

	for (genvar k = 0; k < NDIG; k++) begin : g_cell
		digit_t lower;
		if (k == 0) begin : g_bottom
			assign lower = '0;
		end else begin : g_upper
			assign lower = digits[k-1];
		end
		sitda_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.bit_in    (carry[k]),
			.digit_in  (lower),
			.carry_out (carry[k+1]),
			.digit     (digits[k])
		);
	end

	assign top_digit = digits[NDIG-1];
	assign top_carry = carry[NDIG];

endmodule

// ===== hdl/signed_int_to_decimal_ascii.sv =====
// The value is accepted, its WIDTH bits are shifted through the double-dabble digit cells,
// then a minus sign goes out if negative, leading zeros are skipped and each further digit is sent.
// Throughput: one value at a time; the next value is taken once the last character is loaded.
// The shift-add pass through the row of digit cells takes the bulk of the conversion time.
// Reset (arst_n low, asynchronous) returns control to idle and drops any pending character.
module signed_int_to_decimal_ascii (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           value_valid,
	output logic                           value_ready,
	input  logic signed [sitda_pkg::WIDTH-1:0] value,
	output logic                           char_valid,
	input  logic                           char_ready,
	output logic [7:0]                     char_code,
	output logic                           last
);
	import sitda_pkg::*;

	state_t             state_q, state_d;
	logic [WIDTH-1:0]   mag_q;
	logic               neg_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [REM_W-1:0]   rem_q;
	logic               started_q;
	logic               out_valid_q;
	logic [7:0]         char_q;
	logic               last_q;

	cell_ctl_t          ctl;
	digit_t             top_digit;
	logic               top_carry;
	logic               take_in;
	logic               load_out;
	logic               skip;
	logic               emit_sign;
	logic               emit_digit;
	logic [WIDTH-1:0]   mag_in;

	// The output register frees whenever it is empty or its character transfers
	assign load_out = !out_valid_q || char_ready;
	assign take_in  = value_valid && value_ready;

	// Unsigned magnitude, so the most negative value converts too
	assign mag_in = value[WIDTH-1] ? (~value + 1'b1) : value;

	// Leading zeros are shifted out silently; a lone zero digit is still sent
	assign skip       = (state_q == ST_EMIT) && !started_q && (top_digit == '0)
	                    && (rem_q != REM_W'(1));
	assign emit_sign  = (state_q == ST_SIGN) && load_out;
	assign emit_digit = (state_q == ST_EMIT) && !skip && load_out;

	sitda_chain u_chain (
		.clk       (clk),
		.ctl       (ctl),
		.bit_in    (mag_q[WIDTH-1]),
		.top_digit (top_digit),
		.top_carry (top_carry)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take_in) state_d = ST_CONV;
			end
			ST_CONV: begin
				if (cnt_q == CNT_W'(WIDTH - 1)) state_d = neg_q ? ST_SIGN : ST_EMIT;
			end
			ST_SIGN: begin
				if (load_out) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_digit && rem_q == REM_W'(1)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the state machine: handshake and cell commands
	always_comb begin
		value_ready = 1'b0;
		ctl         = '0;
		case (state_q)
			ST_IDLE: begin
				value_ready = 1'b1;
				ctl.clear   = take_in;
			end
			ST_CONV: begin
				ctl.dab = 1'b1;
			end
			ST_SIGN: begin
				ctl = '0;
			end
			ST_EMIT: begin
				ctl.mov = skip || emit_digit;
			end
			default: ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			started_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_sign || emit_digit) begin
				out_valid_q <= 1'b1;
			end else if (char_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take_in) begin
				started_q <= 1'b0;
			end else if (emit_digit) begin
				started_q <= 1'b1;
			end
		end
	end

	// Datapath registers; hold unless a step moves them
	always_ff @(posedge clk) begin
		if (take_in) begin
			mag_q <= mag_in;
			neg_q <= value[WIDTH-1];
			cnt_q <= '0;
		end else if (state_q == ST_CONV) begin
			mag_q <= {mag_q[WIDTH-2:0], top_carry};
			cnt_q <= cnt_q + 1'b1;
		end
		if (state_q == ST_CONV) begin
			rem_q <= REM_W'(NDIG);
		end else if (skip || emit_digit) begin
			rem_q <= rem_q - 1'b1;
		end
		if (emit_sign) begin
			char_q <= CHAR_MINUS;
			last_q <= 1'b0;
		end else if (emit_digit) begin
			char_q <= CHAR_ZERO + {4'd0, top_digit};
			last_q <= (rem_q == REM_W'(1));
		end
	end

	assign char_valid = out_valid_q;
	assign char_code  = char_q;
	assign last       = last_q;

endmodule

// ===== tb/tb.sv =====
module tb;

	import sitda_pkg::*;

	// Clock period is 4; give up well past the slowest legal run.
	localparam int CYCLE_LIMIT = 600000;
	// Cycles to watch for stray characters once the text queue drains.
	localparam int SETTLE_CYCLES = 3 * WIDTH;
	// Length of the receiver hold-off that backs the block up into its input.
	localparam int LONG_HOLD = 400;
	localparam int NUM_CASES = 20;

	// One character of expected decimal text
	typedef struct {
		logic [7:0] code;
		logic       last;
	} text_char_t;

	// Directed row: an empty text means the predictor supplies the answer
	typedef struct {
		logic signed [WIDTH-1:0] value;
		string                   text;
	} text_case_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    value_valid = 1'b0;
	logic                    value_ready;
	logic signed [WIDTH-1:0] value = '0;
	logic                    char_valid;
	logic                    char_ready = 1'b0;
	logic [7:0]              char_code;
	logic                    last;

	text_char_t pending_text[$];
	int         mismatch_count = 0;
	int         cycle_count = 0;
	int         sender_idle_pct = 0;
	int         receiver_stall_pct = 0;
	int         hold_requests = 0;
	int         holds_served = 0;
	int         hold_left = 0;

	// Extremes, sign flips and digit-count boundaries; the two alternating bit
	// patterns together with the extremes toggle every input bit both ways.
	text_case_t directed_cases [NUM_CASES] = '{
		'{0, "0"},
		'{1, "1"},
		'{-1, "-1"},
		'{9, "9"},
		'{10, "10"},
		'{-10, "-10"},
		'{7, "7"},
		'{-99, "-99"},
		'{100, ""},
		'{12345, "12345"},
		'{999999999, "999999999"},
		'{1000000000, "1000000000"},
		'{-1000000000, "-1000000000"},
		'{32'sh7FFF_FFFF, "2147483647"},
		'{32'sh8000_0000, "-2147483648"},
		'{32'sh8000_0001, "-2147483647"},
		'{32'sh5555_5555, ""},
		'{32'shAAAA_AAAA, ""},
		'{32'sh0F0F_0F0F, ""},
		'{-4096, ""}
	};

	signed_int_to_decimal_ascii DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.value_valid(value_valid),
		.value_ready(value_ready),
		.value      (value),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_code  (char_code),
		.last       (last)
	);

	always #2 clk = ~clk;

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Work out the decimal text of one value and queue it. The magnitude is
	// kept unsigned so that the most negative value negates onto itself and
	// still reads as 2^(WIDTH-1).
	function automatic void queue_decimal_text(input logic signed [WIDTH-1:0] v);
		logic [WIDTH-1:0] raw;
		logic [WIDTH-1:0] mag;
		logic [3:0]       digits[$];
		text_char_t       ch;
		raw = v;
		mag = raw[WIDTH-1] ? -raw : raw;
		do begin
			digits.push_front(4'(mag % 10));
			mag = mag / 10;
		end while (mag != 0);
		if (raw[WIDTH-1]) begin
			ch.code = CHAR_MINUS;
			ch.last = 1'b0;
			pending_text.push_back(ch);
		end
		foreach (digits[i]) begin
			ch.code = CHAR_ZERO + 8'(digits[i]);
			ch.last = (i == digits.size() - 1);
			pending_text.push_back(ch);
		end
	endfunction

	// Queue text typed straight into the table.
	function automatic void queue_typed_text(input string text);
		text_char_t ch;
		for (int i = 0; i < text.len(); i++) begin
			ch.code = text[i];
			ch.last = (i == text.len() - 1);
			pending_text.push_back(ch);
		end
	endfunction

	// Random value biased toward the interesting spots: tiny numbers, powers of
	// ten and their neighbors, values of random length, and the two extremes.
	function automatic logic signed [WIDTH-1:0] pick_value();
		logic signed [WIDTH-1:0] v;
		logic signed [WIDTH-1:0] decade;
		int                      k;
		case ($urandom_range(5))
			0: begin
				v = $urandom_range(20);
			end
			1: begin
				k = $urandom_range(9);
				decade = 1;
				repeat (k) decade = decade * 10;
				v = decade + $signed($urandom_range(2)) - 1;
			end
			2: begin
				v = $urandom >> $urandom_range(WIDTH - 1);
			end
			3: begin
				v = $urandom_range(1) ? 32'sh7FFF_FFFF - $urandom_range(3)
					: 32'sh8000_0000 + $urandom_range(3);
				return v;
			end
			default: begin
				return $urandom;
			end
		endcase
		// flip the sign half the time
		if ($urandom_range(1))
			v = -v;
		return v;
	endfunction

	// Offer one value, idling first at the sender's current rate, and hold it
	// until the transfer. Valid goes low only inside a gap, so a value that
	// follows straight on keeps valid high and just swaps the payload.
	task automatic offer_value(input logic signed [WIDTH-1:0] v, input string text);
		while ($urandom_range(99) < sender_idle_pct) begin
			value_valid <= 1'b0;
			@(posedge clk);
		end
		value_valid <= 1'b1;
		value <= v;
		do
			@(posedge clk);
		while (!value_ready);
		if (text.len() == 0)
			queue_decimal_text(v);
		else
			queue_typed_text(text);
	endtask

	task automatic run_random(input int count, input int idle_pct, input int stall_pct);
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		repeat (count) offer_value(pick_value(), "");
	endtask

	// Receiver: pick ready for the next edge and check each character transfer
	// against the oldest expected one.
	always @(posedge clk) begin
		if (arst_n && char_valid && char_ready) begin
			if (pending_text.size() == 0) begin
				$error("unexpected character: char_code %0d last %0b", char_code, last);
				mismatch_count++;
			end else begin
				text_char_t want;
				want = pending_text.pop_front();
				if (char_code !== want.code) begin
					$error("char_code: expected %0d, got %0d", want.code, char_code);
					mismatch_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, last);
					mismatch_count++;
				end
			end
		end
		// take a new hold-off request, then drop ready for the whole stretch
		if (holds_served != hold_requests) begin
			holds_served <= hold_requests;
			hold_left <= LONG_HOLD;
			char_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			char_ready <= 1'b0;
		end else begin
			char_ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, no idling on either side
		foreach (directed_cases[i])
			offer_value(directed_cases[i].value, directed_cases[i].text);

		run_random(90, 0, 0);
		run_random(70, 88, 0);
		run_random(70, 0, 88);
		run_random(90, 20, 20);

		// back the block up: freeze the receiver while values keep coming
		hold_requests++;
		run_random(50, 0, 0);

		// drop valid right at the last transfer so no stale value is offered
		value_valid <= 1'b0;
		while (pending_text.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/sitda_pkg.sv
hdl/sitda_cell.sv
hdl/sitda_chain.sv
hdl/signed_int_to_decimal_ascii.sv
tb/tb.sv
